>>> rtl/core/sliding_window_peak_rate_monitor_macros.svh
// Assertion macros for the sliding window peak rate monitor.
// Included by the top level only; needs nothing else.
`ifndef SLIDING_WINDOW_PEAK_RATE_MONITOR_MACROS_SVH
`define SLIDING_WINDOW_PEAK_RATE_MONITOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SWPM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swpm: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SWPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swpm: next-cycle check failed");

`endif

>>> rtl/core/swpm_pkg.sv
// Shared types and constants of the sliding window peak rate monitor.
// Used by the controller, the datapath and the top level; no dependencies.
package swpm_pkg;

  localparam int unsigned RING_DEPTH_DEF = 1024;

  localparam logic [9:0]  FAIL_LOW   = 10'd500;
  localparam logic [9:0]  FAIL_HIGH  = 10'd599;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [31:0] WORD_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] WINDOW_RST = 32'd60;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 136;

  // One ring slot: stamp of the event and its running index
  typedef struct packed {
    logic [31:0] index;
    logic [31:0] stamp;
  } ring_entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture an input transaction
    logic push;  // write the record into the ring
    logic pop;   // retire the oldest entry
    logic eval;  // take the window count and update the peak
    logic emit;  // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic timed;
    logic ring_empty;
    logic pop_hit;
    logic out_free;
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PUSH  = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_TEST  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

>>> rtl/core/sliding_window_peak_rate_monitor.sv
// Sliding window peak rate monitor: one result transaction per event record,
// giving the failure tally, the count of events inside the last
// window_seconds and the largest such window seen with its begin and end
// stamps. An untimed record with an empty ring goes straight to its result;
// other records read the ring tail and test it, timed ones after a push.
// Each entry that ages out of the window costs one read of the ring memory
// tail port and one compare. A finished result waits in an output
// register, so the next record is taken while it is still pending. There is
// no clearing pass after reset: only slots that have been written are used.
// Built from swpm_pkg, swpm_ctrl, swpm_dp and the assertion macro header.
`include "sliding_window_peak_rate_monitor_macros.svh"

module sliding_window_peak_rate_monitor #(
  parameter int unsigned RING_DEPTH = swpm_pkg::RING_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // window_seconds register
  input  logic                              cfg_we_i,
  input  logic [31:0]                       cfg_wdata_i,
  // tdata: stamp [31:0], status_code [41:32], zero [47:42]
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [swpm_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // tuser: has_time [0]
  input  logic                              s_axis_tuser_i,
  // tdata: is_failure [0], failure_total [32:1], window_count [48:33],
  // peak_count [64:49], peak_begin [96:65], peak_end [128:97],
  // ring_overflow [129], zero [135:130]
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [swpm_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  swpm_pkg::cmd_t    cmd;
  swpm_pkg::status_t st;

  swpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_timed_i (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  swpm_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_timed_i  (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  // A result loaded by the sequencer shows up on the master side
  `SWPM_ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, cmd.emit, m_axis_tvalid_o)
  // The freshly pushed entry keeps the ring non-empty while retiring
  `SWPM_ASSERT_IMPLIES(a_pop_nonempty, clk_i, rst_ni, cmd.pop, !st.ring_empty)
  // No result is loaded while a new record may be taken
  `SWPM_ASSERT_IMPLIES(a_ready_no_emit, clk_i, rst_ni, s_axis_tready_o, !cmd.emit)

endmodule

>>> rtl/core/swpm_ctrl.sv
// Sequencer of the sliding window peak rate monitor.
// Depends on swpm_pkg for the command, status and state types.
module swpm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_timed_i,
  output logic               in_ready_o,
  input  swpm_pkg::status_t  st_i,
  output swpm_pkg::cmd_t     cmd_o
);

  swpm_pkg::state_e state_q, state_d;

  // Decide the next step and issue datapath commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      swpm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_timed_i) begin
            state_d = swpm_pkg::ST_PUSH;
          end else if (!st_i.ring_empty) begin
            state_d = swpm_pkg::ST_FETCH;
          end else begin
            state_d = swpm_pkg::ST_DONE;
          end
        end
      end
      swpm_pkg::ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = swpm_pkg::ST_FETCH;
      end
      swpm_pkg::ST_FETCH: begin
        // tail entry is read into the memory output register
        state_d = swpm_pkg::ST_TEST;
      end
      swpm_pkg::ST_TEST: begin
        if (st_i.timed && st_i.pop_hit) begin
          cmd_o.pop = 1'b1;
          state_d   = swpm_pkg::ST_FETCH;
        end else begin
          cmd_o.eval = 1'b1;
          state_d    = swpm_pkg::ST_DONE;
        end
      end
      swpm_pkg::ST_DONE: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = swpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swpm_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swpm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/swpm_dp.sv
// Datapath of the sliding window peak rate monitor: ring memory, pointers,
// counters, peak tracking and the result register. Depends on swpm_pkg.
module swpm_dp #(
  parameter int unsigned RING_DEPTH = swpm_pkg::RING_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [31:0]                         cfg_wdata_i,
  input  logic                                in_timed_i,
  input  logic [swpm_pkg::IN_DATA_W-1:0]      in_data_i,
  input  swpm_pkg::cmd_t                      cmd_i,
  output swpm_pkg::status_t                   st_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [swpm_pkg::OUT_DATA_W-1:0]     out_data_o
);

  localparam int unsigned PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(RING_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);

  logic [31:0]        win_q;
  logic [PTR_W-1:0]   head_q, tail_q;
  logic [FILL_W-1:0]  fill_q;
  logic [31:0]        idx_q, fail_cnt_q;
  logic [15:0]        best_cnt_q;
  logic [31:0]        best_begin_q, best_end_q;
  logic               timed_q, is_fail_q, ovf_q;
  logic [31:0]        stamp_q;
  logic [9:0]         status_q;
  logic [15:0]        count_q;
  logic               out_valid_q;
  logic [swpm_pkg::OUT_DATA_W-1:0] out_data_q;

  swpm_pkg::ring_entry_t ring_mem [RING_DEPTH];
  swpm_pkg::ring_entry_t rd_q;

  logic [PTR_W-1:0] head_nxt, tail_nxt;
  logic             ring_full, fail_hit;
  logic [31:0]      age, span;
  logic [15:0]      count_sat;

  assign head_nxt  = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
  assign tail_nxt  = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
  assign ring_full = (fill_q == FILL_FULL);
  assign fail_hit  = (status_q >= swpm_pkg::FAIL_LOW) && (status_q <= swpm_pkg::FAIL_HIGH);

  // Age of the oldest entry against the current stamp
  assign age = stamp_q - rd_q.stamp;

  // Window count, saturating
  assign span      = idx_q - rd_q.index;
  assign count_sat = (span >= 32'(swpm_pkg::COUNT_MAX)) ? swpm_pkg::COUNT_MAX
                                                       : 16'(span + 32'd1);

  assign st_o.timed      = timed_q;
  assign st_o.ring_empty = (fill_q == '0);
  assign st_o.pop_hit    = (stamp_q > rd_q.stamp) && (age > win_q);
  assign st_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Ring memory: write the new record at the head, read the tail each cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      ring_mem[head_q] <= '{index: idx_q, stamp: stamp_q};
    end
    rd_q <= ring_mem[tail_q];
  end

  // Capture the record being worked on
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      stamp_q  <= in_data_i[31:0];
      status_q <= in_data_i[41:32];
    end
  end

  // Window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= swpm_pkg::WINDOW_RST;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  // Ring pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.push) begin
      head_q <= head_nxt;
      if (ring_full) begin
        tail_q <= tail_nxt;
      end else begin
        fill_q <= fill_q + 1'b1;
      end
    end else if (cmd_i.pop) begin
      tail_q <= tail_nxt;
      fill_q <= fill_q - 1'b1;
    end
  end

  // Per-record flags and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timed_q   <= 1'b0;
      is_fail_q <= 1'b0;
      ovf_q     <= 1'b0;
      count_q   <= '0;
    end else if (cmd_i.load) begin
      timed_q   <= in_timed_i;
      is_fail_q <= 1'b0;
      ovf_q     <= 1'b0;
      count_q   <= '0;
    end else begin
      if (cmd_i.push) begin
        is_fail_q <= fail_hit;
        ovf_q     <= ring_full;
      end
      if (cmd_i.eval) begin
        count_q <= count_sat;
      end
    end
  end

  // Running counters and peak window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      fail_cnt_q   <= '0;
      best_cnt_q   <= '0;
      best_begin_q <= '0;
      best_end_q   <= '0;
    end else begin
      if (cmd_i.push && fail_hit && (fail_cnt_q != swpm_pkg::WORD_MAX)) begin
        fail_cnt_q <= fail_cnt_q + 32'd1;
      end
      if (cmd_i.eval && timed_q && (count_sat > best_cnt_q)) begin
        best_cnt_q   <= count_sat;
        best_begin_q <= rd_q.stamp;
        best_end_q   <= stamp_q;
      end
      if (cmd_i.emit && (idx_q != swpm_pkg::WORD_MAX)) begin
        idx_q <= idx_q + 32'd1;
      end
    end
  end

  // Result register: load on emit, drop once the transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {6'd0, ovf_q, best_end_q, best_begin_q, best_cnt_q,
                     count_q, fail_cnt_q, is_fail_q};
    end
  end

endmodule

>>> verif/peak_rate_checker.sv
// Result checker for the sliding window peak rate monitor testbench.
// Watches the record, result and register channels, predicts every result
// and compares it field by field; depends on swpm_pkg for widths and limits.
module peak_rate_checker
  import swpm_pkg::*;
#(
  parameter int unsigned DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [31:0]           cfg_wdata_i,
  input  logic                  rec_valid_i,
  input  logic                  rec_ready_i,
  // stamp [31:0], status_code [41:32], zero [47:42]
  input  logic [IN_DATA_W-1:0]  rec_data_i,
  // has_time [0]
  input  logic                  rec_timed_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic [OUT_DATA_W-1:0] res_data_i,
  output int                    fault_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One result transaction, lowest field last
  typedef struct packed {
    logic        ring_overflow;
    logic [31:0] peak_end;
    logic [31:0] peak_begin;
    logic [15:0] peak_count;
    logic [15:0] window_count;
    logic [31:0] failure_total;
    logic        is_failure;
  } window_report_t;

  // Predicted state of the monitor
  logic [31:0] win_len;
  logic [31:0] slot_stamp [DEPTH];
  logic [31:0] slot_index [DEPTH];
  int unsigned head, tail, fill;
  logic [31:0] evt_index;
  logic [31:0] fail_tally;
  logic [15:0] top_count;
  logic [31:0] top_begin, top_end;

  window_report_t expected_reports[$];
  window_report_t got, want;

  // Advance the window by one event record and build its result
  function automatic window_report_t predict_report(input logic timed,
                                                    input logic [31:0] stamp,
                                                    input logic [9:0] status);
    window_report_t rpt;
    logic [32:0] span;
    rpt = '0;
    if (timed) begin
      if (status >= FAIL_LOW && status <= FAIL_HIGH) begin
        rpt.is_failure = 1'b1;
        if (fail_tally != WORD_MAX) fail_tally = fail_tally + 32'd1;
      end
      // drop the oldest entry to make room
      if (fill >= DEPTH) begin
        tail = (tail + 1) % DEPTH;
        fill = fill - 1;
        rpt.ring_overflow = 1'b1;
      end
      slot_stamp[head] = stamp;
      slot_index[head] = evt_index;
      head = (head + 1) % DEPTH;
      fill = fill + 1;
      // retire entries that lie strictly outside the window
      while (fill > 0 && stamp > slot_stamp[tail] &&
             stamp - slot_stamp[tail] > win_len) begin
        tail = (tail + 1) % DEPTH;
        fill = fill - 1;
      end
    end
    if (fill == 0) begin
      rpt.window_count = '0;
    end else begin
      span = {1'b0, evt_index - slot_index[tail]} + 33'd1;
      rpt.window_count = (span > 33'(COUNT_MAX)) ? COUNT_MAX : span[15:0];
    end
    // a tie keeps the earlier peak
    if (timed && rpt.window_count > top_count) begin
      top_count = rpt.window_count;
      top_begin = slot_stamp[tail];
      top_end   = stamp;
    end
    if (evt_index != WORD_MAX) evt_index = evt_index + 32'd1;
    rpt.failure_total = fail_tally;
    rpt.peak_count    = top_count;
    rpt.peak_begin    = top_begin;
    rpt.peak_end      = top_end;
    return rpt;
  endfunction

  function automatic string describe(input window_report_t r);
    return $sformatf("fail=%0d total=%0d win=%0d peak=%0d begin=%0d end=%0d ovf=%0d",
                     r.is_failure, r.failure_total, r.window_count, r.peak_count,
                     r.peak_begin, r.peak_end, r.ring_overflow);
  endfunction

  // Count a fault, report only the first few
  task automatic flag_fault(input string msg);
    if (fault_count_o < 10) $display("%s", msg);
    fault_count_o++;
  endtask

  // Predict on each accepted record, compare on each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len    = WINDOW_RST;
      head       = 0;
      tail       = 0;
      fill       = 0;
      evt_index  = '0;
      fail_tally = '0;
      top_count  = '0;
      top_begin  = '0;
      top_end    = '0;
      expected_reports.delete();
      pending_o     = 0;
      fault_count_o = 0;
    end else begin
      if (cfg_we_i) win_len = cfg_wdata_i;
      if (rec_valid_i && rec_ready_i) begin
        expected_reports.push_back(
          predict_report(rec_timed_i, rec_data_i[31:0], rec_data_i[41:32]));
      end
      if (res_valid_i && res_ready_i) begin
        got = res_data_i[$bits(window_report_t)-1:0];
        if (expected_reports.size() == 0) begin
          flag_fault({"result with no record pending: ", describe(got)});
        end else begin
          want = expected_reports.pop_front();
          if (got.is_failure !== want.is_failure ||
              got.failure_total !== want.failure_total ||
              got.window_count !== want.window_count ||
              got.peak_count !== want.peak_count ||
              got.peak_begin !== want.peak_begin ||
              got.peak_end !== want.peak_end ||
              got.ring_overflow !== want.ring_overflow) begin
            flag_fault($sformatf("result mismatch at %0t\n  expected %s\n  actual   %s",
                                 $realtime, describe(want), describe(got)));
          end
        end
      end
      pending_o = expected_reports.size();
    end
  end

endmodule

>>> verif/tb_top.sv
// Testbench top for the sliding window peak rate monitor.
// Drives records, the window register and result back-pressure, and gives
// the verdict; needs swpm_pkg, the monitor RTL and peak_rate_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import swpm_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned DEPTH         = RING_DEPTH_DEF;
  localparam logic [31:0] WINDOW_WIDEST = 32'hFFFF_FFFF;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [31:0]           cfg_wdata_i     = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // stamp [31:0], status_code [41:32], zero [47:42]
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  // has_time [0]
  logic                  s_axis_tuser_i  = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // is_failure [0], failure_total [32:1], window_count [48:33],
  // peak_count [64:49], peak_begin [96:65], peak_end [128:97],
  // ring_overflow [129], zero [135:130]
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  int          fault_count;
  int          pending;
  int          tx_idle_pct = 29;
  int          rx_idle_pct = 87;
  int unsigned cycle_count = 0;
  logic [31:0] now_stamp   = '0;
  logic [31:0] win_now     = WINDOW_RST;

  sliding_window_peak_rate_monitor #(
    .RING_DEPTH (DEPTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  peak_rate_checker #(
    .DEPTH (DEPTH)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .rec_valid_i   (s_axis_tvalid_i),
    .rec_ready_i   (s_axis_tready_o),
    .rec_data_i    (s_axis_tdata_i),
    .rec_timed_i   (s_axis_tuser_i),
    .res_valid_i   (m_axis_tvalid_o),
    .res_ready_i   (m_axis_tready_i),
    .res_data_i    (m_axis_tdata_o),
    .fault_count_o (fault_count),
    .pending_o     (pending)
  );

  always #1 clk_i = ~clk_i;

  // Stall the result channel at random
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Status mix: failures, their edges, ordinary codes, codes above 999
  function automatic logic [9:0] pick_status();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return 10'($urandom_range(FAIL_LOW, FAIL_HIGH));
    if (roll < 40) begin
      case ($urandom_range(0, 3))
        0:       return FAIL_LOW - 10'd1;
        1:       return FAIL_LOW;
        2:       return FAIL_HIGH;
        default: return FAIL_HIGH + 10'd1;
      endcase
    end
    if (roll < 95) return 10'($urandom_range(0, 999));
    return 10'($urandom_range(1000, 1023));
  endfunction

  // Offer one record, with random idle cycles ahead; returns at a falling
  // edge with valid still high so back-to-back records stay contiguous
  task automatic send_record(input logic timed, input logic [31:0] stamp,
                             input logic [9:0] status);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_DATA_W - 42){1'b0}}, status, stamp};
    s_axis_tuser_i  <= timed;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Stamps that mostly repeat or rise in small or window-sized steps, with some late ones
  task automatic send_random_record();
    int unsigned roll, lim;
    logic [31:0] stamp;
    roll = $urandom_range(0, 99);
    lim  = (win_now > 1000) ? 2000 : 2 * win_now + 2;
    if (roll < 35) begin
      stamp = now_stamp;
    end else if (roll < 80) begin
      now_stamp += $urandom_range(1, 3);
      stamp = now_stamp;
    end else if (roll < 92) begin
      now_stamp += $urandom_range(1, lim);
      stamp = now_stamp;
    end else if (roll < 97) begin
      stamp = (now_stamp > 50) ? now_stamp - $urandom_range(1, 50) : 32'd0;
    end else begin
      now_stamp += $urandom_range(0, 1 << 24);
      stamp = now_stamp;
    end
    send_record($urandom_range(0, 99) < 85, stamp, pick_status());
  endtask

  // Hold off new records until every result has been taken
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Set the window on an idle block, then run random records
  task automatic run_chunk(input logic [31:0] window, input int n);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= window;
    win_now      = window;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (n) send_random_record();
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset window of 60: failure edges, untimed records, pop boundaries
    send_record(1'b0, 32'd0, 10'd0);
    send_record(1'b1, 32'd0, FAIL_LOW);
    send_record(1'b1, 32'd10, FAIL_HIGH);
    send_record(1'b1, 32'd10, FAIL_LOW - 10'd1);
    send_record(1'b1, 32'd10, FAIL_HIGH + 10'd1);
    send_record(1'b1, 32'd20, 10'd1023);
    send_record(1'b1, 32'd30, 10'd999);
    send_record(1'b0, 32'd40, 10'd550);
    // distance equal to the window keeps the entry, one more drops it
    send_record(1'b1, 32'd70, 10'd0);
    send_record(1'b1, 32'd71, 10'd200);
    // a stamp behind the oldest one pops nothing
    send_record(1'b1, 32'd5, 10'd300);
    send_record(1'b1, 32'd200, 10'd404);
    now_stamp = 200;

    run_chunk(32'd1, 40);
    run_chunk(32'd0, 40);
    run_chunk(WINDOW_WIDEST, 40);
    run_chunk(32'd100, 40);

    tx_idle_pct = 87;
    rx_idle_pct = 29;
    run_chunk(32'd1000, 40);
    run_chunk(32'd2, 40);
    run_chunk($urandom, 40);
    run_chunk(32'd30, 40);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_chunk(32'd60, 40);
    run_chunk(32'd5, 40);
    run_chunk(WINDOW_WIDEST, 40);
    // fill the ring and keep pushing so the oldest entries are dropped
    repeat (DEPTH + 80) send_record(1'b1, now_stamp, pick_status());
    repeat (3) send_record(1'b1, now_stamp, pick_status());

    // narrow window, then the top of the stamp range
    run_chunk(32'd1, 20);
    send_record(1'b1, 32'hFFFF_FFFE, 10'd0);
    send_record(1'b1, 32'hFFFF_FFFF, FAIL_LOW);
    send_record(1'b1, 32'hFFFF_FFFF, 10'd1023);
    send_record(1'b0, 32'hFFFF_FFFF, 10'd1023);

    drain();
    repeat (16) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
